@@ design/emv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Eased value morpher package
// Shared constants, codes, the stored stage record and the cosine series used
// to build the quarter-wave table.
// ----------------------------------------------------------------------------
package emv_pkg;

  localparam int DEF_CHANNELS       = 8;
  localparam int DEF_STAGES         = 4;
  localparam int DEF_COS_TABLE_SIZE = 256;

  localparam int VAL_W  = 32;
  localparam int TIME_W = 32;
  localparam int Q_W    = 16;
  localparam int E_W    = 17;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_BREAK  = 2'd3;

  localparam logic [2:0] EASE_LINEAR = 3'd0;
  localparam logic [2:0] EASE_QUAD   = 3'd1;
  localparam logic [2:0] EASE_INVQ   = 3'd2;
  localparam logic [2:0] EASE_SIG    = 3'd3;
  localparam logic [2:0] EASE_ACCEL  = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_STEP   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_IDLE = 2'd2;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Divisors (2k-1)(2k) of the cosine series terms.
  localparam longint SERIES_DIV [1:8] = '{64'sd2, 64'sd12, 64'sd30, 64'sd56,
                                          64'sd90, 64'sd132, 64'sd182, 64'sd240};

  typedef struct packed {
    logic [2:0]        easing;
    logic [VAL_W-1:0]  from_v;
    logic [VAL_W-1:0]  to_v;
    logic [TIME_W-1:0] beg;
    logic [TIME_W-1:0] fin;
  } stage_t;

  localparam int STAGE_W = $bits(stage_t);

  // Cosine of an angle in Q30 by its Taylor series, rounded to Q16.
  function automatic longint cos_q16(longint ang);
    longint sq;
    longint term;
    longint sum;
    longint v;
    sq   = (ang * ang) / Q30_ONE;
    term = Q30_ONE;
    sum  = term;
    for (int k = 1; k <= 8; k++) begin
      term = -((term * sq) / Q30_ONE) / SERIES_DIV[k];
      sum  = sum + term;
    end
    if (sum < 0) sum = 0;
    v = (sum + 8192) / 16384;
    if (v > 65536) v = 65536;
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/emv_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module emv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wa,
  input  wire logic [WIDTH-1:0]                     wd,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra,
  output logic      [WIDTH-1:0]                     rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule
`default_nettype wire

@@ design/emv_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Progress divider
// Restoring divider giving floor((num << 16) / den) one bit per cycle,
// for num below den; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module emv_div
  import emv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] num,
  input  wire logic [TIME_W-1:0] den,
  output logic                   done,
  output logic      [Q_W-1:0]    quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] den_r;
  logic [Q_W-1:0]    quo_r;
  logic [TIME_W:0]   rem2;
  logic              ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = (den_r != '0) && (rem2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
        rem_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? TIME_W'(rem2 - {1'b0, den_r}) : rem2[TIME_W-1:0];
        quo_r <= {quo_r[Q_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

@@ design/emv_ease.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Easing unit
// Five-stage pipeline that shapes the progress fraction and blends the start
// and end values of a stage.
// ----------------------------------------------------------------------------
module emv_ease
  import emv_pkg::*;
#(
  parameter int COS_TABLE_SIZE = DEF_COS_TABLE_SIZE
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    go,
  input  wire logic        [2:0]       easing,
  input  wire logic        [Q_W-1:0]   p,
  input  wire logic signed [VAL_W-1:0] from_v,
  input  wire logic signed [VAL_W-1:0] to_v,
  output logic                         done,
  output logic signed      [VAL_W-1:0] value
);

  localparam int T_W = $clog2(COS_TABLE_SIZE + 1);
  localparam int K_W = $clog2(2 * COS_TABLE_SIZE + 1);

  logic [E_W-1:0] tab [COS_TABLE_SIZE + 1];

  for (genvar gi = 0; gi <= COS_TABLE_SIZE; gi++) begin : g_tab
    localparam longint ANG = (HALF_PI_Q30 * gi) / COS_TABLE_SIZE;
    localparam logic [E_W-1:0] TV = E_W'(cos_q16(ANG));
    assign tab[gi] = TV;
  end

  logic [4:0] v_r;

  logic        [2:0]       typ1_r, typ2_r;
  logic        [Q_W-1:0]   p1_r, p2_r;
  logic        [E_W-1:0]   sq1_r, sq2_r, qq1_r, qq2_r;
  logic signed [VAL_W:0]   diff1_r, diff2_r, diff3_r;
  logic signed [VAL_W-1:0] from1_r, from2_r, from3_r, from4_r;
  logic signed [E_W:0]     cval_r;
  logic        [E_W-1:0]   e_r;
  logic signed [50:0]      prod_r;
  logic signed [VAL_W-1:0] value_r;

  logic [31:0]       pp;
  logic [E_W-1:0]    q;
  logic [33:0]       qq;
  logic [Q_W-1:0]    x;
  logic [31:0]       kk;
  logic [15:0]       k0;
  logic [K_W-1:0]    k;
  logic signed [E_W:0] cval;
  logic signed [E_W+1:0] sig;
  logic [E_W-1:0]    e;

  always_comb begin
    pp = 32'(p) * 32'(p);
    q  = E_W'(65536) - E_W'(p);
    qq = 34'(q) * 34'(q);
    x  = (typ1_r == EASE_ACCEL) ? sq1_r[Q_W-1:0] : p1_r;
    kk = 32'(x) * 32'(2 * COS_TABLE_SIZE) + 32'd32768;
    k0 = kk[31:16];
    if (32'(k0) > 32'(2 * COS_TABLE_SIZE)) begin
      k = K_W'(2 * COS_TABLE_SIZE);
    end else begin
      k = K_W'(k0);
    end
    if (32'(k) <= 32'(COS_TABLE_SIZE)) begin
      cval = $signed({1'b0, tab[T_W'(k)]});
    end else begin
      cval = -$signed({1'b0, tab[T_W'(K_W'(2 * COS_TABLE_SIZE) - k)]});
    end
    sig = (E_W+2)'(65536) - (E_W+2)'(cval_r);
    case (typ2_r)
      EASE_QUAD:  e = sq2_r;
      EASE_INVQ:  e = E_W'(65536) - qq2_r;
      EASE_SIG:   e = sig[E_W:1];
      EASE_ACCEL: e = sig[E_W:1];
      default:    e = E_W'(p2_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], go};
    end
    typ1_r  <= easing;
    p1_r    <= p;
    sq1_r   <= E_W'(pp >> 16);
    qq1_r   <= E_W'(qq >> 16);
    diff1_r <= {to_v[VAL_W-1], to_v} - {from_v[VAL_W-1], from_v};
    from1_r <= from_v;
    typ2_r  <= typ1_r;
    p2_r    <= p1_r;
    sq2_r   <= sq1_r;
    qq2_r   <= qq1_r;
    cval_r  <= cval;
    diff2_r <= diff1_r;
    from2_r <= from1_r;
    e_r     <= e;
    diff3_r <= diff2_r;
    from3_r <= from2_r;
    prod_r  <= 51'(diff3_r) * $signed({1'b0, e_r});
    from4_r <= from3_r;
    value_r <= from4_r + VAL_W'(prod_r >>> 16);
  end

  assign done  = v_r[4];
  assign value = value_r;

endmodule
`default_nettype wire

@@ design/multistage_eased_value_morpher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Multistage eased value morpher
// Per-channel queues of eased morph stages with tick-driven evaluation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high until
// the request is complete, so one request is handled at a time.
// A start, finish or break request answers with one command status result.
// A tick request walks the channels in order and gives one result per
// completed stage and one step update per active channel, then a tick
// done result marked with out_last. Each result is shown for one cycle on
// out_strobe and cannot be held off by the receiver.
// Stage records live in one RAM with a registered read. A completed stage
// passes through the scan and check states, an active channel also waits on
// the serial progress divider and then the easing pipeline, and an idle
// channel passes through the scan state only.
// Reset empties every queue at once; stage slots are only read after they
// are written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module multistage_eased_value_morpher
  import emv_pkg::*;
#(
  parameter int CHANNELS           = DEF_CHANNELS,
  parameter int STAGES_PER_CHANNEL = DEF_STAGES,
  parameter int COS_TABLE_SIZE     = DEF_COS_TABLE_SIZE
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic        [1:0]       in_op,
  input  wire logic        [2:0]       in_channel,
  input  wire logic        [2:0]       in_easing_type,
  input  wire logic signed [VAL_W-1:0] in_current_value,
  input  wire logic signed [VAL_W-1:0] in_target_value,
  input  wire logic        [31:0]      in_duration,
  input  wire logic        [31:0]      in_now_time,
  output logic                         out_strobe,
  output logic             [1:0]       out_result_kind,
  output logic             [2:0]       out_channel,
  output logic signed      [VAL_W-1:0] out_new_value,
  output logic             [1:0]       out_status,
  output logic                         out_any_changed,
  output logic                         out_last
);

  localparam int SLOTS = CHANNELS * STAGES_PER_CHANNEL;
  localparam int SL_W  = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CH_W  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int SC_W  = $clog2(CHANNELS + 1);
  localparam int HD_W  = STAGES_PER_CHANNEL > 1 ? $clog2(STAGES_PER_CHANNEL) : 1;
  localparam int CN_W  = $clog2(STAGES_PER_CHANNEL + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_SCAN, S_CHK, S_DIV, S_EASE
  } state_t;

  state_t             state_r;
  logic [1:0]         op_r;
  logic [CH_W-1:0]    cch_r;
  logic [2:0]         cch_raw_r;
  logic [2:0]         easing_r;
  logic [VAL_W-1:0]   cur_r;
  logic [VAL_W-1:0]   tgt_r;
  logic [31:0]        dur_r;
  logic [31:0]        now_r;
  logic [SC_W-1:0]    sch_r;
  logic               changed_r;
  stage_t             stg_r;
  logic [HD_W-1:0]    head_r [CHANNELS];
  logic [CN_W-1:0]    cnt_r  [CHANNELS];

  logic               ostb_r, olast_r, ochg_r;
  logic [1:0]         okind_r, ostat_r;
  logic [2:0]         och_r;
  logic [VAL_W-1:0]   oval_r;

  logic               ram_we;
  logic [SL_W-1:0]    ram_wa, ram_ra;
  stage_t             ram_wd, ram_rd;

  logic [CH_W-1:0]    in_ch, sch;
  logic               in_ch_ok;
  logic [HD_W-1:0]    c_head, c_tail, c_lastp, s_head, s_head_nxt;
  logic [CN_W-1:0]    c_cnt, s_cnt;
  logic [CN_W:0]      sum_t, sum_l, sum_h;
  logic [32:0]        fin_sum;
  logic [31:0]        new_beg;
  stage_t             new_stg;

  logic               div_go, div_done;
  logic [Q_W-1:0]     div_q;
  logic               ease_go, ease_done;
  logic [VAL_W-1:0]   ease_val;

  function automatic logic [SL_W-1:0] slot(logic [CH_W-1:0] ch, logic [HD_W-1:0] idx);
    return SL_W'(int'(ch) * STAGES_PER_CHANNEL + int'(idx));
  endfunction

  always_comb begin
    in_ch    = CH_W'(in_channel);
    in_ch_ok = 32'(in_channel) < 32'(CHANNELS);
    sch      = sch_r[CH_W-1:0];
    c_head   = head_r[state_r == S_IDLE ? in_ch : cch_r];
    c_cnt    = cnt_r[state_r == S_IDLE ? in_ch : cch_r];
    s_head   = head_r[sch];
    s_cnt    = cnt_r[sch];
    sum_t    = (CN_W+1)'(c_head) + (CN_W+1)'(c_cnt);
    sum_l    = sum_t - 1'b1;
    c_tail   = (sum_t >= (CN_W+1)'(STAGES_PER_CHANNEL)) ?
               HD_W'(sum_t - (CN_W+1)'(STAGES_PER_CHANNEL)) : HD_W'(sum_t);
    c_lastp  = (sum_l >= (CN_W+1)'(STAGES_PER_CHANNEL)) ?
               HD_W'(sum_l - (CN_W+1)'(STAGES_PER_CHANNEL)) : HD_W'(sum_l);
    sum_h    = (CN_W+1)'(s_head) + 1'b1;
    s_head_nxt = (sum_h >= (CN_W+1)'(STAGES_PER_CHANNEL)) ? '0 : HD_W'(sum_h);

    new_beg = (c_cnt != '0) ? ram_rd.fin : now_r;
    fin_sum = 33'(new_beg) + 33'(dur_r);
    new_stg.easing = easing_r;
    new_stg.from_v = (c_cnt != '0) ? ram_rd.to_v : cur_r;
    new_stg.to_v   = tgt_r;
    new_stg.beg    = new_beg;
    new_stg.fin    = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];

    ram_ra = '0;
    case (state_r)
      S_IDLE: ram_ra = slot(in_ch, (in_op == OP_START) ? c_lastp : c_head);
      S_SCAN: ram_ra = slot(sch, s_head);
      default: ram_ra = '0;
    endcase

    ram_we = 1'b0;
    ram_wa = slot(cch_r, c_head);
    ram_wd = ram_rd;
    if (state_r == S_CMD) begin
      if (op_r == OP_START && c_cnt < CN_W'(STAGES_PER_CHANNEL)) begin
        ram_we = 1'b1;
        ram_wa = slot(cch_r, c_tail);
        ram_wd = new_stg;
      end else if (op_r == OP_FINISH && c_cnt != '0) begin
        ram_we = 1'b1;
        ram_wd.fin = '0;
      end
    end
  end

  assign div_go  = (state_r == S_CHK) && (now_r < ram_rd.fin);
  assign ease_go = (state_r == S_DIV) && div_done;

  emv_ram #(.WIDTH(STAGE_W), .DEPTH(SLOTS)) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  emv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   ((now_r > ram_rd.beg) ? now_r - ram_rd.beg : 32'd0),
    .den   (ram_rd.fin - ram_rd.beg),
    .done  (div_done),
    .quo   (div_q)
  );

  emv_ease #(.COS_TABLE_SIZE(COS_TABLE_SIZE)) u_ease (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (ease_go),
    .easing (stg_r.easing),
    .p      (div_q),
    .from_v (stg_r.from_v),
    .to_v   (stg_r.to_v),
    .done   (ease_done),
    .value  (ease_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ostb_r    <= 1'b0;
      changed_r <= 1'b0;
      sch_r     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      ostb_r  <= 1'b0;
      olast_r <= 1'b0;
      ochg_r  <= 1'b0;
      ostat_r <= STAT_OK;
      oval_r  <= '0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r      <= in_op;
            cch_r     <= in_ch;
            cch_raw_r <= in_channel;
            easing_r  <= in_easing_type;
            cur_r     <= in_current_value;
            tgt_r     <= in_target_value;
            dur_r     <= in_duration;
            now_r     <= in_now_time;
            sch_r     <= '0;
            changed_r <= 1'b0;
            if (in_op == OP_TICK) begin
              state_r <= S_SCAN;
            end else if (!in_ch_ok) begin
              ostb_r  <= 1'b1;
              okind_r <= KIND_STATUS;
              och_r   <= in_channel;
              ostat_r <= STAT_IDLE;
              olast_r <= 1'b1;
            end else begin
              state_r <= S_CMD;
            end
          end
        end
        S_CMD: begin
          ostb_r  <= 1'b1;
          okind_r <= KIND_STATUS;
          och_r   <= cch_raw_r;
          olast_r <= 1'b1;
          state_r <= S_IDLE;
          if (op_r == OP_START) begin
            if (c_cnt >= CN_W'(STAGES_PER_CHANNEL)) begin
              ostat_r <= STAT_FULL;
            end else begin
              cnt_r[cch_r] <= c_cnt + 1'b1;
            end
          end else if (c_cnt == '0) begin
            ostat_r <= STAT_IDLE;
          end else if (op_r == OP_BREAK) begin
            cnt_r[cch_r]  <= '0;
            head_r[cch_r] <= '0;
          end
        end
        S_SCAN: begin
          if (sch_r == SC_W'(CHANNELS)) begin
            ostb_r  <= 1'b1;
            okind_r <= KIND_DONE;
            och_r   <= '0;
            ochg_r  <= changed_r;
            olast_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (s_cnt == '0) begin
            sch_r <= sch_r + 1'b1;
          end else begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          stg_r     <= ram_rd;
          changed_r <= 1'b1;
          if (now_r >= ram_rd.fin) begin
            ostb_r  <= 1'b1;
            okind_r <= KIND_END;
            och_r   <= 3'(sch_r);
            oval_r  <= ram_rd.to_v;
            cnt_r[sch] <= s_cnt - 1'b1;
            if (s_cnt == CN_W'(1)) begin
              head_r[sch] <= '0;
              sch_r       <= sch_r + 1'b1;
            end else begin
              head_r[sch] <= s_head_nxt;
            end
            state_r <= S_SCAN;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_EASE;
          end
        end
        S_EASE: begin
          if (ease_done) begin
            ostb_r  <= 1'b1;
            okind_r <= KIND_STEP;
            och_r   <= 3'(sch_r);
            oval_r  <= ease_val;
            sch_r   <= sch_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = state_r != S_IDLE;
  assign out_strobe      = ostb_r;
  assign out_result_kind = okind_r;
  assign out_channel     = och_r;
  assign out_new_value   = oval_r;
  assign out_status      = ostat_r;
  assign out_any_changed = ochg_r;
  assign out_last        = olast_r;

endmodule
`default_nettype wire
